// ===== rtl/keypad_alarm_controller_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Keypad alarm controller assertion macros
// Concurrent assertion shorthands used at the end of the top level. They
// compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define KEYPAD_ALARM_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define KAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad alarm controller: same-cycle check failed");
// Next-cycle implication, disabled while reset is low.
`define KAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad alarm controller: next-cycle check failed");
`else
`define KAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/kac_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller package
// Types, codes and constants shared by the controller and its channels.
// ----------------------------------------------------------------------------
package kac_pkg;

    localparam int CODE_LEN = 6;
    localparam int LEN_W    = $clog2(CODE_LEN + 1);
    localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int CNT_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 16;

    typedef logic [LEN_W-1:0]           t_len;
    typedef logic [3:0]                 t_digit;
    typedef logic [CODE_LEN-1:0][3:0]   t_code;
    typedef logic [TIME_W-1:0]          t_time;

    localparam t_len  CODE_LEN_L   = t_len'(CODE_LEN);
    localparam t_time TIME_MAX     = '1;
    localparam t_time ALARM_DUR_RST = t_time'(10000);
    localparam t_time BLINK_RST     = t_time'(500);

    localparam t_digit KEY_DIGIT_MAX = 4'd9;
    localparam t_digit KEY_A    = 4'd10;
    localparam t_digit KEY_B    = 4'd11;
    localparam t_digit KEY_D    = 4'd13;
    localparam t_digit KEY_STAR = 4'd14;
    localparam t_digit KEY_HASH = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DUR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 1'd1;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_KEY    = 2'd1,
        ACT_MOTION = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_ALARM    = 2'd2,
        MODE_CHANGE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_ARMED      = 4'd1,
        EV_DISARMED   = 4'd2,
        EV_WRONG_CODE = 4'd3,
        EV_CHANGED    = 4'd4,
        EV_MISMATCH   = 4'd5,
        EV_TOGGLED    = 4'd6,
        EV_CHG_START  = 4'd7,
        EV_SHORT      = 4'd8
    } t_event;

    typedef struct packed {
        t_mode            mode;
        logic             buzzer;
        logic             led;
        logic             entering;
        logic [CNT_W-1:0] entry_count;
        logic             change_step;
        logic             endless_mode;
        t_event           event_res;
    } t_result;

    // Factory code: digits 1, 2, 3, ... wrapping past 9.
    function automatic t_code init_code();
        t_code c;
        for (int i = 0; i < CODE_LEN; i++) begin
            c[i] = t_digit'((i + 1) % 10);
        end
        return c;
    endfunction

endpackage

// ===== rtl/kac_in_if.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller input channel
// Carries one event item: tick, key press or motion.
// ----------------------------------------------------------------------------
interface kac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] key_code;

    modport source (output valid, output action, output key_code, input ready);
    modport sink   (input valid, input action, input key_code, output ready);
endinterface

// ===== rtl/kac_out_if.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller result channel
// Carries one status item per accepted event.
// ----------------------------------------------------------------------------
interface kac_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       buzzer;
    logic       led;
    logic       entering;
    logic [2:0] entry_count;
    logic       change_step;
    logic       endless_mode;
    logic [3:0] event_res;

    modport source (output valid, output mode, output buzzer, output led,
                    output entering, output entry_count, output change_step,
                    output endless_mode, output event_res, input ready);
    modport sink   (input valid, input mode, input buzzer, input led,
                    input entering, input entry_count, input change_step,
                    input endless_mode, input event_res, output ready);
endinterface

// ===== rtl/kac_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller configuration channel
// Register write port: register index and write data.
// ----------------------------------------------------------------------------
interface kac_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kac_pkg::CFG_IDX_W-1:0]    index;
    logic [kac_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/keypad_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller unit
// Disarmed / armed / alarm / code change controller driven by tick, key and
// motion items.
// ----------------------------------------------------------------------------
// Usage:
// i_in takes one event item (tick, key press, motion); o_res returns exactly
// one status item for it: mode, buzzer, LED, entry progress and an event code.
// i_cfg writes the alarm duration (index 0) and the blink half period
// (index 1); it is always ready and should only be used while no item is in
// flight.
// An accepted item is held in the input register, where the state update
// and the result are computed together; the result is registered and then
// appears on o_res. One item per cycle is sustained while o_res is ready,
// set by the single input register feeding the result register.
// A stalled o_res holds its item; the input register still takes a new item,
// which then waits until the result register frees. A third item is refused.
// Reset (synchronous, active low) returns to disarmed with the factory code,
// default timings, no entry in progress, LED on and buzzer off.
// ----------------------------------------------------------------------------
module keypad_alarm_controller_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kac_in_if.sink        i_in,
    kac_out_if.source     o_res,
    kac_cfg_if.sink       i_cfg
);

`include "keypad_alarm_controller_unit_assert.svh"

    // Configuration
    kac_pkg::t_time r_alarm_dur;
    kac_pkg::t_time r_blink_half;

    // Input register
    logic           r_in_vld;
    logic [1:0]     r_in_action;
    kac_pkg::t_digit r_in_key;

    // Controller state
    kac_pkg::t_mode  r_mode,  n_mode;
    logic            r_entry_active, n_entry_active;
    kac_pkg::t_len   r_len,   n_len;
    kac_pkg::t_code  r_digits, n_digits;
    kac_pkg::t_code  r_first,  n_first;
    logic            r_phase, n_phase;
    kac_pkg::t_code  r_stored, n_stored;
    kac_pkg::t_digit r_hist0, n_hist0;
    kac_pkg::t_digit r_hist1, n_hist1;
    kac_pkg::t_time  r_alarm_el, n_alarm_el;
    kac_pkg::t_time  r_blink_el, n_blink_el;
    logic            r_endless, n_endless;
    logic            r_led, n_led;
    logic            r_buzz, n_buzz;

    // Result register
    logic             r_out_vld;
    kac_pkg::t_result r_out, n_out;

    kac_pkg::t_event ev;
    kac_pkg::t_len   len_v;
    logic            is_digit;
    logic            full;
    logic            w_adv;

    assign w_adv      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_dur  <= kac_pkg::ALARM_DUR_RST;
            r_blink_half <= kac_pkg::BLINK_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                kac_pkg::CFG_ALARM_DUR:  r_alarm_dur  <= i_cfg.data;
                kac_pkg::CFG_BLINK_HALF: r_blink_half <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action <= i_in.action;
            r_in_key    <= i_in.key_code;
        end
    end

    // Controller state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= kac_pkg::MODE_DISARMED;
            r_entry_active <= 1'b0;
            r_len          <= '0;
            r_phase        <= 1'b0;
            r_stored       <= kac_pkg::init_code();
            r_hist0        <= '0;
            r_hist1        <= '0;
            r_alarm_el     <= '0;
            r_blink_el     <= '0;
            r_endless      <= 1'b0;
            r_led          <= 1'b1;
            r_buzz         <= 1'b0;
        end else if (w_adv) begin
            r_mode         <= n_mode;
            r_entry_active <= n_entry_active;
            r_len          <= n_len;
            r_phase        <= n_phase;
            r_stored       <= n_stored;
            r_hist0        <= n_hist0;
            r_hist1        <= n_hist1;
            r_alarm_el     <= n_alarm_el;
            r_blink_el     <= n_blink_el;
            r_endless      <= n_endless;
            r_led          <= n_led;
            r_buzz         <= n_buzz;
        end
    end

    // Entry buffers hold meaningful data only once written.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_digits <= n_digits;
            r_first  <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_mode         = r_mode;
        n_entry_active = r_entry_active;
        n_len          = r_len;
        n_digits       = r_digits;
        n_first        = r_first;
        n_phase        = r_phase;
        n_stored       = r_stored;
        n_hist0        = r_hist0;
        n_hist1        = r_hist1;
        n_alarm_el     = r_alarm_el;
        n_blink_el     = r_blink_el;
        n_endless      = r_endless;
        n_led          = r_led;
        n_buzz         = r_buzz;
        ev             = kac_pkg::EV_NONE;
        is_digit       = (r_in_key <= kac_pkg::KEY_DIGIT_MAX);
        len_v          = r_entry_active ? r_len : '0;
        full           = (len_v == kac_pkg::CODE_LEN_L);

        case (r_in_action)
            kac_pkg::ACT_TICK: begin
                if (r_mode == kac_pkg::MODE_ALARM) begin
                    if (r_alarm_el != kac_pkg::TIME_MAX) begin
                        n_alarm_el = r_alarm_el + kac_pkg::t_time'(1);
                    end
                    if (r_blink_el != kac_pkg::TIME_MAX) begin
                        n_blink_el = r_blink_el + kac_pkg::t_time'(1);
                    end
                    // Timeout and blink wait while a code is being typed.
                    if (!r_entry_active) begin
                        if (!r_endless && (n_alarm_el >= r_alarm_dur)) begin
                            n_mode = kac_pkg::MODE_ARMED;
                            n_led  = 1'b1;
                            n_buzz = 1'b0;
                        end else if (n_blink_el >= r_blink_half) begin
                            n_blink_el = '0;
                            n_led      = !r_led;
                        end
                    end
                end
            end
            kac_pkg::ACT_KEY: begin
                if (!r_entry_active && (r_mode == kac_pkg::MODE_DISARMED)) begin
                    n_hist0 = r_hist1;
                    n_hist1 = r_in_key;
                end
                if (r_entry_active || (r_mode == kac_pkg::MODE_CHANGE) || is_digit) begin
                    // The key goes into an entry, which starts empty if none is open.
                    n_entry_active = 1'b1;
                    n_len          = len_v;
                    if (is_digit) begin
                        if (!full) begin
                            n_digits[len_v[kac_pkg::IDX_W-1:0]] = r_in_key;
                            n_len = len_v + kac_pkg::t_len'(1);
                        end
                    end else if (r_in_key == kac_pkg::KEY_D) begin
                        if (len_v != '0) begin
                            n_len = len_v - kac_pkg::t_len'(1);
                        end
                    end else if (r_in_key == kac_pkg::KEY_STAR) begin
                        n_len = '0;
                    end else if (r_in_key == kac_pkg::KEY_HASH) begin
                        n_entry_active = 1'b0;
                        if (r_mode == kac_pkg::MODE_CHANGE) begin
                            if (full && !r_phase) begin
                                // First new code taken; open the confirmation entry.
                                n_first        = r_digits;
                                n_phase        = 1'b1;
                                n_entry_active = 1'b1;
                                n_len          = '0;
                            end else begin
                                if (!full) begin
                                    ev = kac_pkg::EV_SHORT;
                                end else if (r_first == r_digits) begin
                                    n_stored = r_first;
                                    ev       = kac_pkg::EV_CHANGED;
                                end else begin
                                    ev = kac_pkg::EV_MISMATCH;
                                end
                                n_phase = 1'b0;
                                n_mode  = kac_pkg::MODE_DISARMED;
                                n_led   = 1'b1;
                                n_buzz  = 1'b0;
                            end
                        end else if (!full) begin
                            ev = kac_pkg::EV_SHORT;
                        end else if (r_stored != r_digits) begin
                            ev = kac_pkg::EV_WRONG_CODE;
                        end else if (r_mode == kac_pkg::MODE_DISARMED) begin
                            n_mode = kac_pkg::MODE_ARMED;
                            n_led  = 1'b1;
                            n_buzz = 1'b0;
                            ev     = kac_pkg::EV_ARMED;
                        end else begin
                            n_mode = kac_pkg::MODE_DISARMED;
                            n_led  = 1'b1;
                            n_buzz = 1'b0;
                            ev     = kac_pkg::EV_DISARMED;
                        end
                    end
                end else if (r_mode == kac_pkg::MODE_DISARMED) begin
                    if ((r_hist1 == kac_pkg::KEY_A) && (r_in_key == kac_pkg::KEY_A)) begin
                        n_phase        = 1'b0;
                        n_mode         = kac_pkg::MODE_CHANGE;
                        n_led          = 1'b1;
                        n_entry_active = 1'b1;
                        n_len          = '0;
                        ev             = kac_pkg::EV_CHG_START;
                    end else if ((r_hist1 == kac_pkg::KEY_B) &&
                                 (r_in_key == kac_pkg::KEY_B)) begin
                        n_endless = !r_endless;
                        ev        = kac_pkg::EV_TOGGLED;
                    end
                end
            end
            kac_pkg::ACT_MOTION: begin
                if ((r_mode == kac_pkg::MODE_ARMED) && !r_entry_active) begin
                    n_mode     = kac_pkg::MODE_ALARM;
                    n_buzz     = 1'b1;
                    n_alarm_el = '0;
                    n_blink_el = '0;
                end
            end
            default: ;
        endcase

        n_out.mode         = n_mode;
        n_out.buzzer       = n_buzz;
        n_out.led          = n_led;
        n_out.entering     = n_entry_active;
        n_out.entry_count  = n_entry_active ? kac_pkg::CNT_W'(n_len) : '0;
        n_out.change_step  = n_phase;
        n_out.endless_mode = n_endless;
        n_out.event_res    = ev;
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.mode         = r_out.mode;
    assign o_res.buzzer       = r_out.buzzer;
    assign o_res.led          = r_out.led;
    assign o_res.entering     = r_out.entering;
    assign o_res.entry_count  = r_out.entry_count;
    assign o_res.change_step  = r_out.change_step;
    assign o_res.endless_mode = r_out.endless_mode;
    assign o_res.event_res    = r_out.event_res;

    `KAC_ASSERT_IMP(a_phase_only_in_change, i_clk, i_rst_n, r_mode != kac_pkg::MODE_CHANGE, !r_phase)
    `KAC_ASSERT_IMP(a_len_bounded, i_clk, i_rst_n, 1'b1, r_len <= kac_pkg::CODE_LEN_L)
    `KAC_ASSERT_IMP(a_buzzer_in_alarm, i_clk, i_rst_n, 1'b1, (r_mode == kac_pkg::MODE_ALARM) == r_buzz)
    `KAC_ASSERT_NXT(a_held_item_kept, i_clk, i_rst_n, r_in_vld && !w_adv, r_in_vld)

endmodule

// ===== test/tb_keypad_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller unit testbench
// Feeds tick, key and motion items through the input channel and checks every
// status item against a behavioral model of the controller kept in the bench.
// A short directed sequence comes first. Random arm, disarm, code change, alarm
// and noise sequences follow under several alarm and blink timings, with
// random gaps on both channels in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keypad_alarm_controller_unit;
    import kac_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam t_digit     KEY_C    = 4'd12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 265;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] key;
    } t_pad_event;

    logic i_clk;
    logic i_rst_n;

    kac_in_if  pad_ch ();
    kac_out_if res_ch ();
    kac_cfg_if cfg_ch ();

    keypad_alarm_controller_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pad_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    t_pad_event pad_events [$];
    t_result    status_due [$];
    int n_pushed = 0;
    int n_taken = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_alarm = 0;
    int n_settings = 0;
    int cyc = 0;
    int tick_span = 8;
    int event_tally [16];
    bit no_idle = 1'b0;

    // Controller model state.
    t_mode  sys_mode;
    logic   in_entry;
    t_code  entry_buf;
    t_len   entry_len;
    t_code  first_code;
    logic   confirm_step;
    t_code  code_ref;
    t_digit hist_old;
    t_digit hist_new;
    t_time  alarm_ms;
    t_time  blink_ms;
    logic   endless;
    logic   led_on;
    logic   buzz_on;
    t_time  alarm_limit;
    t_time  blink_limit;

    function automatic void reset_model();
        sys_mode     = MODE_DISARMED;
        in_entry     = 1'b0;
        entry_buf    = '0;
        entry_len    = '0;
        first_code   = '0;
        confirm_step = 1'b0;
        for (int i = 0; i < CODE_LEN; i++) begin
            code_ref[i] = t_digit'((i + 1) % 10);
        end
        hist_old    = '0;
        hist_new    = '0;
        alarm_ms    = '0;
        blink_ms    = '0;
        endless     = 1'b0;
        led_on      = 1'b1;
        buzz_on     = 1'b0;
        alarm_limit = t_time'(10000);
        blink_limit = t_time'(500);
    endfunction

    function automatic void switch_mode(t_mode m);
        sys_mode = m;
        if (m == MODE_ALARM) begin
            buzz_on  = 1'b1;
            alarm_ms = '0;
            blink_ms = '0;
        end else begin
            led_on = 1'b1;
            if (m != MODE_CHANGE) begin
                buzz_on = 1'b0;
            end
        end
    endfunction

    function automatic void open_entry();
        in_entry  = 1'b1;
        entry_len = '0;
    endfunction

    function automatic t_event confirm_entry();
        logic   full;
        t_event ev;
        full     = (entry_len == t_len'(CODE_LEN));
        in_entry = 1'b0;
        if (sys_mode == MODE_CHANGE) begin
            if (!full) begin
                ev = EV_SHORT;
            end else if (!confirm_step) begin
                // First new code taken; the confirmation entry opens at once.
                first_code   = entry_buf;
                confirm_step = 1'b1;
                open_entry();
                return EV_NONE;
            end else if (first_code == entry_buf) begin
                code_ref = first_code;
                ev       = EV_CHANGED;
            end else begin
                ev = EV_MISMATCH;
            end
            confirm_step = 1'b0;
            switch_mode(MODE_DISARMED);
            return ev;
        end
        if (!full) return EV_SHORT;
        if (code_ref != entry_buf) return EV_WRONG_CODE;
        if (sys_mode == MODE_DISARMED) begin
            switch_mode(MODE_ARMED);
            return EV_ARMED;
        end
        switch_mode(MODE_DISARMED);
        return EV_DISARMED;
    endfunction

    function automatic t_event entry_keystroke(t_digit k);
        if (k <= KEY_DIGIT_MAX) begin
            if (entry_len < t_len'(CODE_LEN)) begin
                entry_buf[entry_len] = k;
                entry_len = entry_len + t_len'(1);
            end
        end else if (k == KEY_D) begin
            if (entry_len != '0) entry_len = entry_len - t_len'(1);
        end else if (k == KEY_STAR) begin
            entry_len = '0;
        end else if (k == KEY_HASH) begin
            return confirm_entry();
        end
        return EV_NONE;
    endfunction

    function automatic t_event handle_key(t_digit k);
        if (in_entry) return entry_keystroke(k);
        if (sys_mode == MODE_CHANGE) begin
            open_entry();
            return entry_keystroke(k);
        end
        // Only keys pressed while disarmed and outside an entry shift the history.
        if (sys_mode == MODE_DISARMED) begin
            hist_old = hist_new;
            hist_new = k;
        end
        if (k <= KEY_DIGIT_MAX) begin
            open_entry();
            return entry_keystroke(k);
        end
        if (sys_mode != MODE_DISARMED) return EV_NONE;
        if (hist_old == KEY_A && hist_new == KEY_A) begin
            confirm_step = 1'b0;
            switch_mode(MODE_CHANGE);
            open_entry();
            return EV_CHG_START;
        end
        if (hist_old == KEY_B && hist_new == KEY_B) begin
            endless = !endless;
            return EV_TOGGLED;
        end
        return EV_NONE;
    endfunction

    function automatic void handle_tick();
        if (sys_mode != MODE_ALARM) return;
        if (alarm_ms != TIME_MAX) alarm_ms = alarm_ms + t_time'(1);
        if (blink_ms != TIME_MAX) blink_ms = blink_ms + t_time'(1);
        // Counters keep running during an entry, but timeout and blink wait.
        if (in_entry) return;
        if (!endless && alarm_ms >= alarm_limit) begin
            switch_mode(MODE_ARMED);
            return;
        end
        if (blink_ms >= blink_limit) begin
            blink_ms = '0;
            led_on   = !led_on;
        end
    endfunction

    function automatic t_result next_status(logic [1:0] action, t_digit k);
        t_result r;
        t_event  ev;
        ev = EV_NONE;
        case (action)
            ACT_TICK:   handle_tick();
            ACT_KEY:    ev = handle_key(k);
            ACT_MOTION: if (sys_mode == MODE_ARMED && !in_entry) switch_mode(MODE_ALARM);
            default:    ;
        endcase
        r.mode         = sys_mode;
        r.buzzer       = buzz_on;
        r.led          = led_on;
        r.entering     = in_entry;
        r.entry_count  = in_entry ? entry_len : '0;
        r.change_step  = confirm_step;
        r.endless_mode = endless;
        r.event_res    = ev;
        return r;
    endfunction

    function automatic string show_status(t_result r);
        return $sformatf("mode %0d buzzer %0b led %0b entering %0b count %0d step %0b endless %0b event %0d",
                         r.mode, r.buzzer, r.led, r.entering, r.entry_count, r.change_step,
                         r.endless_mode, r.event_res);
    endfunction

    // Input driver: predicts each item as it is accepted.
    always @(posedge i_clk) begin
        t_pad_event nxt;
        if (i_rst_n) begin
            if (pad_ch.valid && pad_ch.ready) begin
                status_due.push_back(next_status(pad_ch.action, pad_ch.key_code));
                n_taken++;
            end
            if (!pad_ch.valid || pad_ch.ready) begin
                if (pad_events.size() != 0 && (no_idle || $urandom_range(99) >= 15)) begin
                    nxt = pad_events.pop_front();
                    pad_ch.valid    <= 1'b1;
                    pad_ch.action   <= nxt.action;
                    pad_ch.key_code <= nxt.key;
                end else begin
                    pad_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.mode         = t_mode'(res_ch.mode);
                got.buzzer       = res_ch.buzzer;
                got.led          = res_ch.led;
                got.entering     = res_ch.entering;
                got.entry_count  = res_ch.entry_count;
                got.change_step  = res_ch.change_step;
                got.endless_mode = res_ch.endless_mode;
                got.event_res    = t_event'(res_ch.event_res);
                n_checked++;
                if (status_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX)
                        $display("unexpected status item: %s", show_status(got));
                end else begin
                    want = status_due.pop_front();
                    event_tally[want.event_res]++;
                    if (want.mode == MODE_ALARM) n_alarm++;
                    if (got.mode !== want.mode || got.buzzer !== want.buzzer ||
                        got.led !== want.led || got.entering !== want.entering ||
                        got.entry_count !== want.entry_count ||
                        got.change_step !== want.change_step ||
                        got.endless_mode !== want.endless_mode ||
                        got.event_res !== want.event_res) begin
                        n_errors++;
                        if (n_errors <= REPORT_MAX) begin
                            $display("status item %0d mismatch", n_checked);
                            $display("  expected %s", show_status(want));
                            $display("  actual   %s", show_status(got));
                        end
                    end
                end
            end
            res_ch.ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d items accepted", cyc, n_taken, n_pushed);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_ev(input logic [1:0] act, input logic [3:0] k);
        t_pad_event e;
        e.action = act;
        e.key    = k;
        pad_events.push_back(e);
        n_pushed++;
    endtask

    task automatic push_key(input t_digit k);
        push_ev(ACT_KEY, k);
    endtask

    function automatic t_code random_code();
        t_code c;
        for (int i = 0; i < CODE_LEN; i++) begin
            c[i] = t_digit'($urandom_range(9));
        end
        return c;
    endfunction

    task automatic push_entry_noise();
        case ($urandom_range(3))
            0:       push_ev(ACT_TICK, 4'($urandom));
            1:       push_ev(ACT_MOTION, 4'($urandom));
            2:       push_key(t_digit'($urandom_range(KEY_C, KEY_A)));
            default: push_ev(ACT_NONE, 4'($urandom));
        endcase
    endtask

    // Types a full code and confirms it, with occasional corrections and
    // unrelated items mixed in.
    task automatic enter_code(input t_code c);
        for (int i = 0; i < CODE_LEN; i++) begin
            if (i > 0 && $urandom_range(9) == 0) push_entry_noise();
            if ($urandom_range(11) == 0) begin
                push_key(t_digit'($urandom_range(9)));
                push_key(KEY_D);
            end
            push_key(c[i]);
        end
        // A digit past a full entry is dropped.
        if ($urandom_range(7) == 0) push_key(t_digit'($urandom_range(9)));
        push_key(KEY_HASH);
    endtask

    task automatic sync_pads();
        while (n_taken != n_pushed) @(posedge i_clk);
    endtask

    task automatic settle();
        sync_pads();
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_time val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_ALARM_DUR) alarm_limit = val;
        else blink_limit = val;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_scenario();
        int    pick;
        int    n;
        t_code c;
        pick = $urandom_range(99);
        if (pick < 25) begin
            enter_code(code_ref);
        end else if (pick < 33) begin
            enter_code(random_code());
        end else if (pick < 40) begin
            n = $urandom_range(CODE_LEN - 1);
            for (int i = 0; i < n; i++) push_key(t_digit'($urandom_range(9)));
            if ($urandom_range(3) == 0) push_key(KEY_STAR);
            push_key(KEY_HASH);
        end else if (pick < 52) begin
            push_key(KEY_A);
            push_key(KEY_A);
            c = random_code();
            enter_code(c);
            n = $urandom_range(9);
            if (n < 7) begin
                enter_code(c);
            end else if (n < 9) begin
                enter_code(random_code());
            end else begin
                push_key(t_digit'($urandom_range(9)));
                push_key(KEY_HASH);
            end
            // The stored code may have changed; later entries need it.
            sync_pads();
        end else if (pick < 57) begin
            push_key(KEY_B);
            push_key(KEY_B);
        end else if (pick < 72) begin
            push_ev(ACT_MOTION, 4'($urandom));
            n = $urandom_range(tick_span);
            for (int i = 0; i < n; i++) push_ev(ACT_TICK, 4'($urandom));
        end else if (pick < 92) begin
            n = $urandom_range(tick_span, 1);
            for (int i = 0; i < n; i++) push_ev(ACT_TICK, 4'($urandom));
        end else begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) push_ev(2'($urandom), 4'($urandom));
            if ($urandom_range(1) == 0) push_key(KEY_HASH);
        end
    endtask

    initial begin
        int    phase_end;
        t_time dur;
        t_time half;
        i_rst_n         = 1'b0;
        pad_ch.valid    = 1'b0;
        pad_ch.action   = ACT_TICK;
        pad_ch.key_code = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_ALARM_DUR;
        cfg_ch.data     = '0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_ALARM_DUR, t_time'(2));
        write_reg(CFG_BLINK_HALF, t_time'(1));
        n_settings++;

        push_ev(ACT_NONE, KEY_HASH);
        push_ev(ACT_MOTION, 4'd0);
        push_key(KEY_B);
        push_key(KEY_B);
        push_key(KEY_B);
        push_key(4'd0);
        push_key(KEY_D);
        push_key(KEY_D);
        push_key(KEY_STAR);
        push_key(KEY_HASH);
        for (int i = 0; i < CODE_LEN; i++) push_key(code_ref[i]);
        push_key(KEY_HASH);
        push_key(KEY_A);
        push_ev(ACT_MOTION, 4'd0);
        push_ev(ACT_TICK, 4'd0);
        push_ev(ACT_TICK, 4'd0);
        push_ev(ACT_MOTION, 4'd0);
        push_key(4'd9);
        push_key(KEY_C);
        push_ev(ACT_TICK, 4'd0);
        push_key(KEY_HASH);
        push_ev(ACT_TICK, 4'd0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin dur = '0;       half = '0;       end
                1: begin dur = 16'd1;    half = 16'd1;    end
                2: begin dur = TIME_MAX; half = TIME_MAX; end
                3: begin
                    dur  = t_time'($urandom_range(30, 2));
                    half = t_time'($urandom_range(6, 1));
                end
                4: begin
                    dur  = t_time'($urandom_range(50, 5));
                    half = t_time'($urandom_range(12, 2));
                end
                default: begin
                    dur  = t_time'($urandom);
                    half = t_time'($urandom_range(8, 1));
                end
            endcase
            write_reg(CFG_ALARM_DUR, dur);
            write_reg(CFG_BLINK_HALF, half);
            n_settings++;
            tick_span = (dur < 60) ? int'(dur) + 3 : 40;
            no_idle   = (p == 3);
            phase_end = n_pushed + PHASE_ITEMS;
            while (n_pushed < phase_end) begin
                while (pad_events.size() > 6) @(posedge i_clk);
                add_scenario();
            end
        end

        sync_pads();
        no_idle = 1'b0;
        for (int w = 0; w < 2000 && status_due.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (status_due.size() != 0) begin
            $display("%0d expected status items never arrived", status_due.size());
            n_errors += status_due.size();
        end

        $display("%0d items checked under %0d timing settings, %0d of them in alarm mode",
                 n_checked, n_settings, n_alarm);
        $display("events: armed %0d disarmed %0d wrong %0d changed %0d mismatch %0d toggled %0d short %0d",
                 event_tally[EV_ARMED], event_tally[EV_DISARMED], event_tally[EV_WRONG_CODE],
                 event_tally[EV_CHANGED], event_tally[EV_MISMATCH], event_tally[EV_TOGGLED],
                 event_tally[EV_SHORT]);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures", n_errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
